FILE: src/perspective_world_to_screen_assert.svh
// Assertion macros for the perspective projection block.
// Clocked on aclk, disabled while aresetn is low; empty under SYNTHESIS.
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_ASSERT_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_ASSERT_SVH
`ifndef SYNTHESIS
`define PW2S_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pw2s assertion failed");
`define PW2S_ASSERT_NEXT(lbl, cond, res) \
    `PW2S_ASSERT(lbl, (cond) |=> (res))
`else
`define PW2S_ASSERT(lbl, prop)
`define PW2S_ASSERT_NEXT(lbl, cond, res)
`endif
`endif

FILE: src/pw2s_pkg.sv
// Shared types, codes and helpers of the perspective projection block.
// No dependencies.
package pw2s_pkg;

    localparam int QUOT_BITS = 41;
    localparam logic [QUOT_BITS-1:0] QUOT_LIMIT = {1'b1, {(QUOT_BITS-1){1'b0}}};
    localparam int SLOTS = 12;
    localparam int SIZE_W = 14;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;

    typedef struct packed {
        logic wz;
        logic negx;
        logic negy;
    } side_t;

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

FILE: src/perspective_world_to_screen.sv
// Top level: coefficient table, dot products, scaling and screen mapping.
// Depends on pw2s_pkg, pw2s_div and perspective_world_to_screen_assert.svh.
//
// Usage: the s_ channel carries beats of two kinds. A load beat (action 0)
// writes one of twelve coefficients and produces nothing; a project beat
// (action 1) produces one m_ beat with screen x, screen y and w in signed
// fixed point, or zeros with w_zero set when w is exactly zero.
// Screen width and height sit in the APB registers at 0x0 and 0x4 and the user
// must write them only while the block is idle; the block does not enforce this.
// A project beat passes from the edge that accepts it to the edge that
// raises m_valid through four stages of products, sums, magnitudes and size
// scaling, one divider entry stage, 41 quotient stages of one bit each and
// the output register. It takes one beat per cycle unless the receiver stalls.
// When the receiver stalls with a result pending, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated.
// Reset clears the coefficient table, the valid bits and sets the screen
// size to 1920 by 1080.
`include "perspective_world_to_screen_assert.svh"
module perspective_world_to_screen #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [0:0]  s_action,
    input  logic [3:0]  s_coef_index,
    input  logic signed [31:0] s_coef_value,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y,
    output logic signed [31:0] m_depth_w,
    output logic [0:0]  m_w_zero,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int QB    = pw2s_pkg::QUOT_BITS;
    localparam int SW    = pw2s_pkg::SIZE_W;
    localparam int SUM_W = 66 - FRAC_BITS;
    localparam int PW    = SUM_W + SW;
    localparam int NW    = PW + FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic [SW-1:0] width_reg, height_reg;
    logic signed [31:0] coef_reg [0:pw2s_pkg::SLOTS-1];
    logic adv, s_fire;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign s_fire  = s_valid && s_ready;
    assign pready  = 1'b1;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= pw2s_pkg::WIDTH_RESET;
            height_reg <= pw2s_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                pw2s_pkg::CFG_SCREEN_WIDTH:  width_reg  <= pwdata[SW-1:0];
                pw2s_pkg::CFG_SCREEN_HEIGHT: height_reg <= pwdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pw2s_pkg::CFG_SCREEN_WIDTH:  prdata = {{(32-SW){1'b0}}, width_reg};
            pw2s_pkg::CFG_SCREEN_HEIGHT: prdata = {{(32-SW){1'b0}}, height_reg};
            default:                     prdata = '0;
        endcase
    end

    // coefficient table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pw2s_pkg::SLOTS; i++) coef_reg[i] <= '0;
        end else if (s_fire && s_action == pw2s_pkg::ACT_LOAD
                     && s_coef_index < 4'(pw2s_pkg::SLOTS)) begin
            coef_reg[s_coef_index] <= s_coef_value;
        end
    end

    // stage 1: products
    logic signed [63:0] prod_reg [0:8];
    logic signed [31:0] trans_reg[0:2];
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [31:0] pos [0:2];
    assign pos[0] = s_pos_x;
    assign pos[1] = s_pos_y;
    assign pos[2] = s_pos_z;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                trans_reg[r] <= coef_reg[r*4+3];
                for (int c = 0; c < 3; c++)
                    prod_reg[r*3+c] <= coef_reg[r*4+c] * pos[c];
            end
        end
    end

    // stage 2: row sums
    logic signed [SUM_W-1:0] acc_reg [0:2];
    logic signed [SUM_W-1:0] acc_next[0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc_next[r] = SUM_W'(trans_reg[r]);
            for (int c = 0; c < 3; c++)
                acc_next[r] = acc_next[r] + SUM_W'(prod_reg[r*3+c] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) acc_reg[r] <= acc_next[r];
        end
    end

    // stage 3: magnitudes and signs
    logic [SUM_W-1:0] ax_reg, ay_reg, ad3_reg;
    logic signed [SUM_W-1:0] w3_reg, w4_reg;
    pw2s_pkg::side_t s3_reg, s4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg   <= acc_reg[0][SUM_W-1] ? -acc_reg[0] : acc_reg[0];
            ay_reg   <= acc_reg[1][SUM_W-1] ? -acc_reg[1] : acc_reg[1];
            ad3_reg  <= acc_reg[2][SUM_W-1] ? -acc_reg[2] : acc_reg[2];
            w3_reg   <= acc_reg[2];
            s3_reg.wz   <= acc_reg[2] == '0;
            s3_reg.negx <= acc_reg[0][SUM_W-1] != acc_reg[2][SUM_W-1];
            s3_reg.negy <= acc_reg[1][SUM_W-1] != acc_reg[2][SUM_W-1];
        end
    end

    // stage 4: scale by screen size
    logic [PW-1:0] px_reg, py_reg;
    logic [SUM_W-1:0] d4_reg;

    function automatic logic [PW-1:0] ad_mul(input logic [SUM_W-1:0] a,
                                             input logic [SW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= ad_mul(ax_reg, width_reg);
            py_reg <= ad_mul(ay_reg, height_reg);
            d4_reg <= ad3_reg;
            w4_reg <= w3_reg;
            s4_reg <= s3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_fire && s_action == pw2s_pkg::ACT_PROJECT;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // quotient pipelines
    logic [NW-1:0] nx, ny;
    logic [SUM_W-1:0] dd;
    logic [QB-1:0] qx, qy;

    assign nx = {px_reg, {FRAC_BITS{1'b0}}} + NW'(d4_reg);
    assign ny = {py_reg, {FRAC_BITS{1'b0}}} + NW'(d4_reg);
    assign dd = {d4_reg[SUM_W-2:0], 1'b0};

    pw2s_div #(.NW(NW), .DW(SUM_W)) u_div_x (
        .aclk (aclk), .en (adv), .n_in (nx), .d_in (dd), .q_out (qx)
    );
    pw2s_div #(.NW(NW), .DW(SUM_W)) u_div_y (
        .aclk (aclk), .en (adv), .n_in (ny), .d_in (dd), .q_out (qy)
    );

    logic                    sv_reg [0:QB];
    pw2s_pkg::side_t         sd_reg [0:QB];
    logic signed [SUM_W-1:0] sw_reg [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QB; i++) sv_reg[i] <= 1'b0;
        end else if (adv) begin
            sv_reg[0] <= v4_reg;
            for (int i = 1; i <= QB; i++) sv_reg[i] <= sv_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= s4_reg;
            sw_reg[0] <= w4_reg;
            for (int i = 1; i <= QB; i++) begin
                sd_reg[i] <= sd_reg[i-1];
                sw_reg[i] <= sw_reg[i-1];
            end
        end
    end

    // output stage: screen mapping and clamping
    logic signed [63:0] qsx, qsy, sx, sy;
    logic m_valid_reg;
    logic signed [31:0] m_screen_x_reg, m_screen_y_reg, m_depth_w_reg;
    logic m_w_zero_reg;

    always_comb begin
        qsx = sd_reg[QB].negx ? -64'(qx) : 64'(qx);
        qsy = sd_reg[QB].negy ? -64'(qy) : 64'(qy);
        sx  = (64'(width_reg) <<< (FRAC_BITS - 1)) + qsx + HALF;
        sy  = (64'(height_reg) <<< (FRAC_BITS - 1)) - (qsy + HALF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= sv_reg[QB];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_w_zero_reg <= sd_reg[QB].wz;
            if (sd_reg[QB].wz) begin
                m_screen_x_reg <= '0;
                m_screen_y_reg <= '0;
                m_depth_w_reg  <= '0;
            end else begin
                m_screen_x_reg <= pw2s_pkg::clamp32(sx);
                m_screen_y_reg <= pw2s_pkg::clamp32(sy);
                m_depth_w_reg  <= pw2s_pkg::clamp32(64'(sw_reg[QB]));
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_screen_x = m_screen_x_reg;
    assign m_screen_y = m_screen_y_reg;
    assign m_depth_w  = m_depth_w_reg;
    assign m_w_zero   = m_w_zero_reg;

    `PW2S_ASSERT_NEXT(a_load_no_beat, s_fire && s_action == pw2s_pkg::ACT_LOAD, !v1_reg)
    `PW2S_ASSERT_NEXT(a_stall_holds, !adv, $stable(sv_reg[QB]) && $stable(v4_reg))
    `PW2S_ASSERT(a_wzero_clear, m_valid && m_w_zero |-> {m_screen_x, m_screen_y, m_depth_w} == '0)

endmodule

FILE: src/pw2s_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient limited.
// Depends on pw2s_pkg for the quotient width and limit.
module pw2s_div #(
    parameter int NW = 80,
    parameter int DW = 50
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [NW-1:0]                  n_in,
    input  logic [DW-1:0]                  d_in,
    output logic [pw2s_pkg::QUOT_BITS-1:0] q_out
);
    localparam int QB = pw2s_pkg::QUOT_BITS;
    localparam int HW = NW - QB;

    logic [DW-1:0] r_reg  [0:QB-1];
    logic [QB-1:0] nl_reg [0:QB-1];
    logic [DW-1:0] d_reg  [0:QB-1];
    logic [QB-1:0] q_reg  [0:QB];
    logic          sat_reg[0:QB];

    logic [DW-1:0] hi;
    logic          sat;

    always_comb begin
        hi  = {{(DW-HW){1'b0}}, n_in[NW-1:QB]};
        sat = hi >= d_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= sat ? '0 : hi;
            nl_reg[0]  <= n_in[QB-1:0];
            d_reg[0]   <= d_in;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        always_comb begin
            trial = {r_reg[j], nl_reg[j][QB-1]};
            diff  = trial - {1'b0, d_reg[j]};
            ge    = trial >= {1'b0, d_reg[j]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[j+1]   <= {q_reg[j][QB-2:0], ge};
                sat_reg[j+1] <= sat_reg[j];
            end
        end
        if (j < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    nl_reg[j+1] <= {nl_reg[j][QB-2:0], 1'b0};
                    d_reg[j+1]  <= d_reg[j];
                end
            end
        end
    end

    assign q_out = (sat_reg[QB] || q_reg[QB] > pw2s_pkg::QUOT_LIMIT)
                 ? pw2s_pkg::QUOT_LIMIT : q_reg[QB];

endmodule

FILE: bench/perspective_world_to_screen_test.sv
// Self-checking bench for perspective_world_to_screen: a queue-fed driver, a monitor
// and a fixed-point projection predictor compared beat by beat. Depends on pw2s_pkg
// and the block itself.
`timescale 1ns / 100ps
module perspective_world_to_screen_test;

    typedef struct {
        logic        action;
        logic [3:0]  slot;
        logic [31:0] coef;
        logic [31:0] px, py, pz;
    } point_beat_t;

    typedef struct {
        logic [31:0] sx, sy, w;
        logic        wz;
    } screen_pos_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [0:0] s_action = '0;
    logic [3:0] s_coef_index = '0;
    logic signed [31:0] s_coef_value = '0, s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_screen_x, m_screen_y, m_depth_w;
    logic [0:0] m_w_zero;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    point_beat_t pending_beats[$];
    screen_pos_t expected_pos[$];
    logic signed [31:0] coef_tab[pw2s_pkg::SLOTS];
    logic [13:0] scr_w = 14'd1920, scr_h = 14'd1080;
    int send_idle = 0, recv_stall = 0;
    int errors = 0;
    int cycles = 0;

    perspective_world_to_screen u_dut (.*);

    always #2 aclk = ~aclk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic logic signed [63:0] row_sum(input int row, input logic signed [31:0] x,
            input logic signed [31:0] y, input logic signed [31:0] z);
        logic signed [63:0] acc, c0, c1, c2;
        c0 = coef_tab[row*4];
        c1 = coef_tab[row*4+1];
        c2 = coef_tab[row*4+2];
        acc = coef_tab[row*4+3];
        acc += (c0 * 64'(x)) >>> 16;
        acc += (c1 * 64'(y)) >>> 16;
        acc += (c2 * 64'(z)) >>> 16;
        return acc;
    endfunction

    function automatic logic signed [63:0] scaled_term(input logic signed [63:0] num,
            input logic [13:0] size, input logic signed [63:0] den);
        logic neg;
        logic [127:0] a, d, q;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        if (a == 0 || size == 0) return 64'sd0;
        q = (((a * 128'(size)) << 16) + d) / (d << 1);
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic [31:0] clamp_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic screen_pos_t project_point(input logic signed [31:0] x,
            input logic signed [31:0] y, input logic signed [31:0] z);
        screen_pos_t r;
        logic signed [63:0] cx, cy, w, half;
        half = 64'sd32768;
        cx = row_sum(0, x, y, z);
        cy = row_sum(1, x, y, z);
        w = row_sum(2, x, y, z);
        if (w == 0) begin
            r.sx = '0; r.sy = '0; r.w = '0; r.wz = 1'b1;
        end else begin
            r.sx = clamp_s32($signed({50'd0, scr_w}) * half + scaled_term(cx, scr_w, w) + half);
            r.sy = clamp_s32($signed({50'd0, scr_h}) * half - (scaled_term(cy, scr_h, w) + half));
            r.w = clamp_s32(w);
            r.wz = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2097151)) - 1048576);
            2: return 32'($signed($urandom_range(262143)) - 131072);
            3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic point_beat_t mk_load(input logic [3:0] slot, input logic [31:0] v);
        point_beat_t b;
        b.action = pw2s_pkg::ACT_LOAD; b.slot = slot; b.coef = v;
        b.px = $urandom(); b.py = $urandom(); b.pz = $urandom();
        return b;
    endfunction

    function automatic point_beat_t mk_point(input logic [31:0] x, input logic [31:0] y,
            input logic [31:0] z);
        point_beat_t b;
        b.action = pw2s_pkg::ACT_PROJECT; b.slot = 4'($urandom()); b.coef = $urandom();
        b.px = x; b.py = y; b.pz = z;
        return b;
    endfunction

    // driver
    always @(posedge aclk) begin
        point_beat_t b;
        screen_pos_t p;
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_action == pw2s_pkg::ACT_LOAD) begin
                    if (s_coef_index < pw2s_pkg::SLOTS) coef_tab[s_coef_index] = s_coef_value;
                end else begin
                    p = project_point(s_pos_x, s_pos_y, s_pos_z);
                    expected_pos.push_back(p);
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
                    b = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_action <= b.action;
                    s_coef_index <= b.slot;
                    s_coef_value <= b.coef;
                    s_pos_x <= b.px;
                    s_pos_y <= b.py;
                    s_pos_z <= b.pz;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        screen_pos_t e;
        m_ready <= ($urandom_range(99) >= recv_stall);
        if (aresetn && m_valid && m_ready) begin
            if (expected_pos.size() == 0) begin
                report("unexpected beat", m_screen_x, 32'h0);
            end else begin
                e = expected_pos.pop_front();
                if (m_screen_x !== e.sx) report("screen_x", m_screen_x, e.sx);
                if (m_screen_y !== e.sy) report("screen_y", m_screen_y, e.sy);
                if (m_depth_w !== e.w) report("depth_w", m_depth_w, e.w);
                if (m_w_zero !== e.wz) report("w_zero", 32'(m_w_zero), 32'(e.wz));
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 400000) begin
            $display("perspective_world_to_screen_test failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_screen(input logic [13:0] w, input logic [13:0] h);
        apb_write(3'd0, {18'd0, w});
        apb_write(3'd4, {18'd0, h});
        scr_w = w;
        scr_h = h;
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (pending_beats.size() > 0 || s_valid || expected_pos.size() > 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic fill_random(input int n);
        int i, k;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 25) begin
                pending_beats.push_back(mk_load(4'($urandom_range(11)), pick_value()));
            end else if (k < 28) begin
                pending_beats.push_back(mk_load(4'($urandom_range(15, 12)), $urandom()));
            end else if (k < 31) begin
                pending_beats.push_back(mk_load(4'd11, $urandom_range(1) ? 32'h0 : pick_value()));
            end else begin
                pending_beats.push_back(mk_point(pick_value(), pick_value(), pick_value()));
            end
        end
    endtask

    initial begin
        int ph;
        for (int i = 0; i < pw2s_pkg::SLOTS; i++) coef_tab[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero matrix: w is zero
        pending_beats.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        // near-identity camera
        pending_beats.push_back(mk_load(4'd0, 32'h0001_0000));
        pending_beats.push_back(mk_load(4'd5, 32'h0001_0000));
        pending_beats.push_back(mk_load(4'd10, 32'h0001_0000));
        pending_beats.push_back(mk_load(4'd11, 32'h0000_0000));
        pending_beats.push_back(mk_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000));
        pending_beats.push_back(mk_point(32'hFFFF_0000, 32'h0000_8000, 32'hFFFE_0000));
        pending_beats.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001));
        pending_beats.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        pending_beats.push_back(mk_point(32'h0, 32'h0, 32'h0));
        // ignored slot
        pending_beats.push_back(mk_load(4'd15, 32'hFFFF_FFFF));
        pending_beats.push_back(mk_load(4'd12, 32'h7FFF_FFFF));
        pending_beats.push_back(mk_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000));
        pending_beats.push_back(mk_load(4'd3, 32'h7FFF_FFFF));
        pending_beats.push_back(mk_load(4'd7, 32'h8000_0000));
        pending_beats.push_back(mk_load(4'd8, 32'h8000_0000));
        pending_beats.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        pending_beats.push_back(mk_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        drain();

        set_screen(14'd0, 14'd8191);
        pending_beats.push_back(mk_point(32'h0001_0000, 32'h0005_0000, 32'h0001_0000));
        pending_beats.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle = 0; recv_stall = 0; set_screen(14'd1, 14'd1); end
                1: begin send_idle = 72; recv_stall = 0; set_screen(14'd8192, 14'd8192); end
                2: begin send_idle = 0; recv_stall = 72; set_screen(14'd1920, 14'd1080); end
                3: begin
                    send_idle = 24; recv_stall = 24;
                    set_screen(14'($urandom_range(8192, 1)), 14'($urandom_range(8192, 1)));
                end
                default: begin
                    send_idle = 0; recv_stall = 0;
                    set_screen(14'($urandom()), 14'd0);
                end
            endcase
            fill_random(250);
            drain();
        end

        if (errors == 0) begin
            $display("perspective_world_to_screen_test passed");
        end else begin
            $display("perspective_world_to_screen_test failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/pw2s_pkg.sv
src/pw2s_div.sv
src/perspective_world_to_screen.sv
bench/perspective_world_to_screen_test.sv
